/* src/lzss_stream_decompressor_top_assert.svh */
// Assertion macros for the LZSS stream decompressor checker.
// Needs nothing else; included by the checker file only.
`ifndef LZSS_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define LZSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzsd same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define LZSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzsd next-cycle check failed");

`endif

/* src/lzsd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the LZSS stream decompressor.
// No dependencies; used by the interfaces, the top level and the checker.
package lzsd_pkg;

    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 32;
    localparam int BIT_IDX_W       = 3;
    localparam int LIT_BITS        = 9;
    localparam int WINDOW_BITS_DEF = 13;
    localparam int LENGTH_BITS_DEF = 4;
    localparam int MIN_MATCH_DEF   = 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_COPY,
        S_NOTE
    } t_state;

endpackage

/* src/lzsd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for compressed input and decompressed output.
// Depends on lzsd_pkg for the byte width.
interface lzsd_in_if import lzsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              stream_start;

    modport source (output valid, code_byte, stream_start, input ready);
    modport sink   (input valid, code_byte, stream_start, output ready);
endinterface

interface lzsd_out_if import lzsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              last_of_run;
    logic              stream_done;

    modport source (output valid, out_byte, out_valid, last_of_run, stream_done, input ready);
    modport sink   (input valid, out_byte, out_valid, last_of_run, stream_done, output ready);
endinterface

/* src/lzss_stream_decompressor_top.sv */
`timescale 1ns / 1ps
// Top level of the LZSS stream decompressor: bit-serial token decoder, history RAM, output register.
// Depends on lzsd_pkg, lzsd_if (lzsd_in_if, lzsd_out_if) and lzsd_ram.
//
//  Channel   Direction  Handshake           Payload
//  i_in      in         valid / ready       code_byte, stream_start
//  o_out     out        valid / ready       out_byte, out_valid, last_of_run, stream_done
//  cfg       in         i_cfg_wr_en         i_cfg_wr_data (output_length, 32 bits)
//
// An input request is taken in the idle cycle and its eight bits are then decoded one per cycle,
// and a byte that completes a copy then emits the copied bytes one per cycle
// (up to 2^LENGTH_BITS - 1 + MIN_MATCH), set by the single read port of the history RAM.
// Reset is synchronous and needs no clearing pass: the history is masked by the byte count,
// so entries not yet written in the current stream read as zero.
// A full output register that is not taken stalls the decoder; input ready is high only when idle.

module lzss_stream_decompressor_top import lzsd_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int MIN_MATCH   = MIN_MATCH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data,
    lzsd_in_if.sink            i_in,
    lzsd_out_if.source         o_out
);

    // Token sizes: a flag bit, then the offset field, then the length field.
    localparam int HIST_DEPTH = 1 << WINDOW_BITS;
    localparam int SHELF_W    = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int CNT_W      = $clog2(SHELF_W + 1);
    localparam int LEN_W      = LENGTH_BITS + 1;

    t_state                 r_state, n_state;
    logic [BYTE_W-1:0]      r_code, n_code;
    logic [BIT_IDX_W-1:0]   r_bit, n_bit;
    logic                   r_more, n_more;
    logic [SHELF_W-1:0]     r_shelf, n_shelf;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_flag, n_flag;
    logic [COUNT_W-1:0]     r_bytes, n_bytes;
    logic                   r_fin, n_fin;
    logic [COUNT_W-1:0]     r_olen;
    logic [WINDOW_BITS-1:0] r_pos, n_pos;
    logic [LEN_W-1:0]       r_left, n_left;

    // Read-side bookkeeping for the history RAM: forwarding and never-written masking.
    logic                   r_fwd_hit, n_fwd_hit;
    logic [BYTE_W-1:0]      r_fwd_data;
    logic                   r_rd_zero, n_rd_zero;

    // Output register.
    logic                   r_out_vld;
    logic [BYTE_W-1:0]      r_o_byte;
    logic                   r_o_data;
    logic                   r_o_last;
    logic                   r_o_done;

    logic                   out_load;
    logic [BYTE_W-1:0]      ld_byte;
    logic                   ld_data;
    logic                   ld_last;
    logic                   ld_done;
    logic                   slot_free;

    logic                   ram_we;
    logic [WINDOW_BITS-1:0] ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [WINDOW_BITS-1:0] ram_raddr;
    logic [BYTE_W-1:0]      ram_rdata;

    logic [COUNT_W-1:0]     bytes_inc;
    logic                   prod_done;
    logic [BYTE_W-1:0]      copy_byte;
    logic                   cur_bit;
    logic                   cur_flag;
    logic [SHELF_W-1:0]     sh;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   last_bit;
    logic [COUNT_W-1:0]     eff_bytes;
    logic                   eff_fin;

    lzsd_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (HIST_DEPTH),
        .ADDR_W (WINDOW_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Every produced byte lands at the current byte count modulo the window size.
    assign ram_waddr = r_bytes[WINDOW_BITS-1:0];

    // The byte count never passes output_length, so the increment cannot wrap.
    assign bytes_inc = r_bytes + COUNT_W'(1);
    assign prod_done = (bytes_inc >= r_olen);

    // A read that hits the entry written in the same cycle takes the written byte. An entry at or
    // beyond the fill count, before the window has wrapped once, has not been written this stream.
    assign n_fwd_hit = ram_we && (ram_raddr == ram_waddr);
    assign n_rd_zero = (r_bytes[COUNT_W-1:WINDOW_BITS] == '0) &&
                       (ram_raddr >= r_bytes[WINDOW_BITS-1:0]);
    assign copy_byte = r_fwd_hit ? r_fwd_data : (r_rd_zero ? '0 : ram_rdata);

    assign slot_free = !r_out_vld || o_out.ready;

    // Bit-serial decode of the current code byte, most significant bit first.
    assign cur_bit  = r_code[r_bit];
    assign sh       = {r_shelf[SHELF_W-2:0], cur_bit};
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign cur_flag = (r_cnt == '0) ? cur_bit : r_flag;
    assign last_bit = (r_bit == '0);

    // A stream start clears the counters before the byte is looked at.
    assign eff_bytes = i_in.stream_start ? '0 : r_bytes;
    assign eff_fin   = i_in.stream_start ? 1'b0 : r_fin;

    always_comb begin
        n_state   = r_state;
        n_code    = r_code;
        n_bit     = r_bit;
        n_more    = r_more;
        n_shelf   = r_shelf;
        n_cnt     = r_cnt;
        n_flag    = r_flag;
        n_bytes   = r_bytes;
        n_fin     = r_fin;
        n_pos     = r_pos;
        n_left    = r_left;
        out_load  = 1'b0;
        ld_byte   = '0;
        ld_data   = 1'b0;
        ld_last   = 1'b0;
        ld_done   = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_raddr = r_pos;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_code = i_in.code_byte;
                    n_bit  = '1;
                    if (i_in.stream_start) begin
                        n_shelf = '0;
                        n_cnt   = '0;
                        n_flag  = 1'b0;
                        n_bytes = '0;
                        n_fin   = 1'b0;
                    end
                    if (eff_fin) begin
                        n_state = S_IDLE;
                    end else if (eff_bytes >= r_olen) begin
                        n_state = S_NOTE;
                    end else begin
                        n_state = S_BITS;
                    end
                end
            end

            S_NOTE: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    ld_last  = 1'b1;
                    ld_done  = 1'b1;
                    n_fin    = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_BITS: begin
                if (cur_flag && (cnt_inc == CNT_W'(LIT_BITS))) begin
                    // Literal: store and emit the eight bits after the flag.
                    if (slot_free) begin
                        out_load  = 1'b1;
                        ld_byte   = sh[BYTE_W-1:0];
                        ld_data   = 1'b1;
                        ld_last   = 1'b1;
                        ld_done   = prod_done;
                        ram_we    = 1'b1;
                        ram_wdata = sh[BYTE_W-1:0];
                        n_bytes   = bytes_inc;
                        n_shelf   = '0;
                        n_cnt     = '0;
                        if (prod_done) begin
                            n_fin   = 1'b1;
                            n_state = S_IDLE;
                        end else if (last_bit) begin
                            n_state = S_IDLE;
                        end else begin
                            n_bit = r_bit - BIT_IDX_W'(1);
                        end
                    end
                end else if (!cur_flag && (cnt_inc == CNT_W'(1 + WINDOW_BITS)) &&
                             (sh[WINDOW_BITS-1:0] == '0)) begin
                    // End marker: a bare done notice, the rest of the byte is dropped.
                    if (slot_free) begin
                        out_load = 1'b1;
                        ld_last  = 1'b1;
                        ld_done  = 1'b1;
                        n_fin    = 1'b1;
                        n_shelf  = '0;
                        n_cnt    = '0;
                        n_state  = S_IDLE;
                    end
                end else if (!cur_flag && (cnt_inc == CNT_W'(SHELF_W))) begin
                    // Copy token: start the first history read right away.
                    n_pos     = sh[WINDOW_BITS+LENGTH_BITS-1:LENGTH_BITS] -
                                WINDOW_BITS'(1);
                    n_left    = LEN_W'(sh[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH);
                    ram_raddr = n_pos;
                    n_shelf   = '0;
                    n_cnt     = '0;
                    n_more    = !last_bit;
                    n_bit     = r_bit - BIT_IDX_W'(1);
                    n_state   = S_COPY;
                end else begin
                    n_shelf = sh;
                    n_cnt   = cnt_inc;
                    n_flag  = cur_flag;
                    if (last_bit) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bit = r_bit - BIT_IDX_W'(1);
                    end
                end
            end

            S_COPY: begin
                // Each cycle with a free output slot emits one copied byte and reads the next.
                // A stalled cycle reads the same entry again, so the RAM output needs no holding.
                if (slot_free) begin
                    out_load  = 1'b1;
                    ld_byte   = copy_byte;
                    ld_data   = 1'b1;
                    ld_last   = (r_left == LEN_W'(1)) || prod_done;
                    ld_done   = prod_done;
                    ram_we    = 1'b1;
                    ram_wdata = copy_byte;
                    n_bytes   = bytes_inc;
                    if (prod_done) begin
                        n_fin   = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_left == LEN_W'(1)) begin
                        n_state = r_more ? S_BITS : S_IDLE;
                    end else begin
                        n_left    = r_left - LEN_W'(1);
                        n_pos     = r_pos + WINDOW_BITS'(1);
                        ram_raddr = n_pos;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit     <= '0;
            r_more    <= 1'b0;
            r_shelf   <= '0;
            r_cnt     <= '0;
            r_flag    <= 1'b0;
            r_bytes   <= '0;
            r_fin     <= 1'b0;
            r_olen    <= '0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_bit   <= n_bit;
            r_more  <= n_more;
            r_shelf <= n_shelf;
            r_cnt   <= n_cnt;
            r_flag  <= n_flag;
            r_bytes <= n_bytes;
            r_fin   <= n_fin;
            r_left  <= n_left;
            if (i_cfg_wr_en) begin
                r_olen <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_pos      <= n_pos;
        r_fwd_hit  <= n_fwd_hit;
        r_fwd_data <= ram_wdata;
        r_rd_zero  <= n_rd_zero;
        if (out_load) begin
            r_o_byte <= ld_byte;
            r_o_data <= ld_data;
            r_o_last <= ld_last;
            r_o_done <= ld_done;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.out_byte    = r_o_byte;
    assign o_out.out_valid   = r_o_data;
    assign o_out.last_of_run = r_o_last;
    assign o_out.stream_done = r_o_done;

endmodule

/* src/lzsd_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// A read of the address written in the same cycle returns the old contents.
module lzsd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lzsd_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for the LZSS stream decompressor, bound to the top level.
// Depends on lzsd_pkg and the assertion macros header.
`include "lzss_stream_decompressor_top_assert.svh"

module lzsd_chk import lzsd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_vld,
    input logic              i_out_rdy,
    input logic [BYTE_W-1:0] i_out_byte,
    input logic              i_out_data,
    input logic              i_out_last,
    input logic              i_out_done
);

    // A bare notice always ends the stream and closes the run of its request.
    `LZSD_ASSERT_IMP(a_notice_done, i_clk, i_rst_n, i_out_vld && !i_out_data, i_out_done && i_out_last)

    // A bare notice carries a zero byte.
    `LZSD_ASSERT_IMP(a_notice_zero, i_clk, i_rst_n, i_out_vld && !i_out_data, i_out_byte == '0)

    // Nothing follows the result that ends the stream within the same request.
    `LZSD_ASSERT_IMP(a_done_last, i_clk, i_rst_n, i_out_vld && i_out_done, i_out_last)

    // A stalled result stays offered.
    `LZSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_vld && !i_out_rdy, i_out_vld)

endmodule

bind lzss_stream_decompressor_top lzsd_chk u_lzsd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_vld  (o_out.valid),
    .i_out_rdy  (o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_out_data (o_out.out_valid),
    .i_out_last (o_out.last_of_run),
    .i_out_done (o_out.stream_done)
);
